// ----- rtl/core/im2col_address_generator_defines.svh -----
// Assertion helpers used by the address generator RTL.
`ifndef IM2COL_ADDRESS_GENERATOR_DEFINES_SVH
`define IM2COL_ADDRESS_GENERATOR_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define IAG_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define IAG_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/im2col_pkg.sv -----
package im2col_pkg;

    localparam int MAX_KERNEL = 8;
    localparam int MAX_DIM    = 4096;

    localparam int DIM_W      = 13;
    localparam int CH_W       = 10;
    localparam int POS_W      = 12;
    localparam int TAP_W      = 3;
    localparam int SRC_W      = 34;
    localparam int DST_W      = 40;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 13;
    localparam int S_DATA_W   = 40;
    localparam int M_DATA_W   = 80;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH   = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KERNEL_HEIGHT = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KERNEL_WIDTH  = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PAD_ROWS      = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_PAD_COLS      = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_STRIDE_PAIR   = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_DILATION_PAIR = 4'd7;

    function automatic logic [3:0] clamp_kernel(input logic [3:0] k);
        logic [3:0] r;
        if (k == 4'd0) begin
            r = 4'd1;
        end else if (k > 4'(MAX_KERNEL)) begin
            r = 4'(MAX_KERNEL);
        end else begin
            r = k;
        end
        return r;
    endfunction

    function automatic logic [3:0] nib_or_one(input logic [3:0] v);
        return (v == 4'd0) ? 4'd1 : v;
    endfunction

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
        return (v > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : v;
    endfunction

endpackage

// ----- rtl/core/im2col_address_generator.sv -----
// Channel   Direction  Beat
// s_axis    in         one window: channel, out_row, out_col
// m_axis    out        one kernel tap: offsets, tap indices, pad flag, tlast on final tap
// cfg       in         register index and data, always ready
//
// Each window gives KH*KW output beats, one per cycle while m_tready is high, paced by the tap sequencer.
// Each tap passes through the sequencer, stages 1 to 3 and the output register.
// After reset and after every config write, s_tready stays low
// while the grid size is divided out one quotient bit per cycle.
// m_tready low freezes the pipeline from the output back; empty stages still fill.
`include "im2col_address_generator_defines.svh"

module im2col_address_generator
    import im2col_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_DATA_W-1:0]   s_tdata,   // channel, out_row, out_col

    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_DATA_W-1:0]   m_tdata,   // src_offset, dst_offset, tap_row, tap_col
    output logic                  m_tuser,   // pad_zero
    output logic                  m_tlast,

    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    typedef enum logic [1:0] {G_LOAD, G_DIV, G_DONE} grid_state_t;

    // config registers
    logic [DIM_W-1:0] image_height_reg, image_width_reg;
    logic [3:0]       kernel_height_reg, kernel_width_reg;
    logic [2:0]       pad_rows_reg, pad_cols_reg;
    logic [7:0]       stride_pair_reg, dilation_pair_reg;

    logic cfg_fire;
    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            image_height_reg  <= DIM_W'(8);
            image_width_reg   <= DIM_W'(8);
            kernel_height_reg <= 4'd3;
            kernel_width_reg  <= 4'd3;
            pad_rows_reg      <= 3'd1;
            pad_cols_reg      <= 3'd1;
            stride_pair_reg   <= 8'h11;
            dilation_pair_reg <= 8'h11;
        end else if (cfg_fire) begin
            unique case (cfg_index)
                REG_IMAGE_HEIGHT:  image_height_reg  <= cfg_data[DIM_W-1:0];
                REG_IMAGE_WIDTH:   image_width_reg   <= cfg_data[DIM_W-1:0];
                REG_KERNEL_HEIGHT: kernel_height_reg <= cfg_data[3:0];
                REG_KERNEL_WIDTH:  kernel_width_reg  <= cfg_data[3:0];
                REG_PAD_ROWS:      pad_rows_reg      <= cfg_data[2:0];
                REG_PAD_COLS:      pad_cols_reg      <= cfg_data[2:0];
                REG_STRIDE_PAIR:   stride_pair_reg   <= cfg_data[7:0];
                REG_DILATION_PAIR: dilation_pair_reg <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // effective values
    logic [DIM_W-1:0] h_eff, w_eff;
    logic [3:0]       kh_eff, kw_eff, sv, sh, dv, dh;
    logic [2:0]       kh_m1, kw_m1;

    assign h_eff  = clamp_dim(image_height_reg);
    assign w_eff  = clamp_dim(image_width_reg);
    assign kh_eff = clamp_kernel(kernel_height_reg);
    assign kw_eff = clamp_kernel(kernel_width_reg);
    assign sv     = nib_or_one(stride_pair_reg[7:4]);
    assign sh     = nib_or_one(stride_pair_reg[3:0]);
    assign dv     = nib_or_one(dilation_pair_reg[7:4]);
    assign dh     = nib_or_one(dilation_pair_reg[3:0]);
    assign kh_m1  = 3'(kh_eff - 4'd1);
    assign kw_m1  = 3'(kw_eff - 4'd1);

    // grid size: (room - span) / stride + 1, one quotient bit per cycle
    grid_state_t      grid_state_reg;
    logic [3:0]       grid_cnt_reg;
    logic [DIM_W-1:0] grid_num_v_reg, grid_num_h_reg;
    logic [3:0]       grid_rem_v_reg, grid_rem_h_reg;
    logic             grid_zero_v_reg, grid_zero_h_reg;
    logic [DIM_W-1:0] hc_reg, wc_reg;
    logic [6:0]       kk_reg;

    logic [6:0]       span_v, span_h;
    logic [DIM_W-1:0] room_v, room_h;
    logic [4:0]       rem_sh_v, rem_sh_h;
    logic             ge_v, ge_h;
    logic [3:0]       rem_next_v, rem_next_h;
    logic [DIM_W-1:0] quo_next_v, quo_next_h;
    logic             grid_ready;

    assign span_v = 7'(dv) * 7'(kh_m1) + 7'd1;
    assign span_h = 7'(dh) * 7'(kw_m1) + 7'd1;
    assign room_v = h_eff + DIM_W'({pad_rows_reg, 1'b0});
    assign room_h = w_eff + DIM_W'({pad_cols_reg, 1'b0});

    assign rem_sh_v   = {grid_rem_v_reg, grid_num_v_reg[DIM_W-1]};
    assign rem_sh_h   = {grid_rem_h_reg, grid_num_h_reg[DIM_W-1]};
    assign ge_v       = rem_sh_v >= {1'b0, sv};
    assign ge_h       = rem_sh_h >= {1'b0, sh};
    assign rem_next_v = ge_v ? 4'(rem_sh_v - {1'b0, sv}) : rem_sh_v[3:0];
    assign rem_next_h = ge_h ? 4'(rem_sh_h - {1'b0, sh}) : rem_sh_h[3:0];
    assign quo_next_v = {grid_num_v_reg[DIM_W-2:0], ge_v};
    assign quo_next_h = {grid_num_h_reg[DIM_W-2:0], ge_h};
    assign grid_ready = (grid_state_reg == G_DONE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grid_state_reg <= G_LOAD;
        end else if (cfg_fire) begin
            grid_state_reg <= G_LOAD;
        end else begin
            unique case (grid_state_reg)
                G_LOAD: begin
                    grid_zero_v_reg <= room_v < DIM_W'(span_v);
                    grid_zero_h_reg <= room_h < DIM_W'(span_h);
                    grid_num_v_reg  <= room_v - DIM_W'(span_v);
                    grid_num_h_reg  <= room_h - DIM_W'(span_h);
                    grid_rem_v_reg  <= '0;
                    grid_rem_h_reg  <= '0;
                    grid_cnt_reg    <= '0;
                    kk_reg          <= 7'(kh_eff) * 7'(kw_eff);
                    grid_state_reg  <= G_DIV;
                end
                G_DIV: begin
                    grid_num_v_reg <= quo_next_v;
                    grid_num_h_reg <= quo_next_h;
                    grid_rem_v_reg <= rem_next_v;
                    grid_rem_h_reg <= rem_next_h;
                    grid_cnt_reg   <= grid_cnt_reg + 4'd1;
                    if (grid_cnt_reg == 4'(DIM_W - 1)) begin
                        hc_reg         <= grid_zero_v_reg ? '0 : quo_next_v + DIM_W'(1);
                        wc_reg         <= grid_zero_h_reg ? '0 : quo_next_h + DIM_W'(1);
                        grid_state_reg <= G_DONE;
                    end
                end
                G_DONE: grid_state_reg <= G_DONE;
                default: grid_state_reg <= G_LOAD;
            endcase
        end
    end

    // pipeline ready chain
    logic p1_valid_reg, p2_valid_reg, p3_valid_reg, out_valid_reg;
    logic rdy1, rdy2, rdy3, rdy4;

    assign rdy4 = !out_valid_reg || m_tready;
    assign rdy3 = !p3_valid_reg || rdy4;
    assign rdy2 = !p2_valid_reg || rdy3;
    assign rdy1 = !p1_valid_reg || rdy2;

    // tap sequencer
    logic                    seq_valid_reg;
    logic [TAP_W-1:0]        seq_i_reg, seq_j_reg;
    logic signed [17:0]      seq_ih_reg, seq_iw_reg, seq_col0_reg;
    logic [15:0]             seq_t_reg;
    logic [21:0]             seq_chh_reg;
    logic [POS_W-1:0]        seq_orow_reg, seq_ocol_reg;

    logic [CH_W-1:0]         in_ch;
    logic [POS_W-1:0]        in_row, in_col;
    logic signed [17:0]      row0_c, col0_c;
    logic                    s_fire, seq_last, seq_adv;

    assign in_ch  = s_tdata[CH_W-1:0];
    assign in_row = s_tdata[CH_W+POS_W-1:CH_W];
    assign in_col = s_tdata[CH_W+2*POS_W-1:CH_W+POS_W];
    assign row0_c = $signed(18'(in_row) * 18'(sv) - 18'(pad_rows_reg));
    assign col0_c = $signed(18'(in_col) * 18'(sh) - 18'(pad_cols_reg));

    assign seq_last = (seq_i_reg == kh_m1) && (seq_j_reg == kw_m1);
    assign seq_adv  = seq_valid_reg && rdy1;
    assign s_tready = grid_ready && (!seq_valid_reg || (seq_last && rdy1));
    assign s_fire   = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seq_valid_reg <= 1'b0;
        end else if (s_fire) begin
            seq_valid_reg <= 1'b1;
        end else if (seq_adv && seq_last) begin
            seq_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            seq_i_reg    <= '0;
            seq_j_reg    <= '0;
            seq_ih_reg   <= row0_c;
            seq_iw_reg   <= col0_c;
            seq_col0_reg <= col0_c;
            seq_t_reg    <= 16'(in_ch) * 16'(kk_reg);
            seq_chh_reg  <= 22'(in_ch) * 22'(h_eff);
            seq_orow_reg <= in_row;
            seq_ocol_reg <= in_col;
        end else if (seq_adv && !seq_last) begin
            seq_t_reg <= seq_t_reg + 16'd1;
            if (seq_j_reg == kw_m1) begin
                seq_j_reg  <= '0;
                seq_i_reg  <= seq_i_reg + TAP_W'(1);
                seq_ih_reg <= seq_ih_reg + $signed({14'd0, dv});
                seq_iw_reg <= seq_col0_reg;
            end else begin
                seq_j_reg  <= seq_j_reg + TAP_W'(1);
                seq_iw_reg <= seq_iw_reg + $signed({14'd0, dh});
            end
        end
    end

    // stage 1: bounds check, row base, tap times grid height
    logic             p1_inside_reg, p1_last_reg;
    logic [22:0]      p1_a_reg;
    logic [28:0]      p1_m_reg;
    logic [POS_W-1:0] p1_iw_reg, p1_orow_reg, p1_ocol_reg;
    logic [TAP_W-1:0] p1_i_reg, p1_j_reg;
    logic             inside_c;

    assign inside_c = !seq_ih_reg[17] && !seq_iw_reg[17]
                      && (seq_ih_reg[16:0] < 17'(h_eff))
                      && (seq_iw_reg[16:0] < 17'(w_eff));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
        end else if (rdy1) begin
            p1_valid_reg <= seq_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy1) begin
            p1_inside_reg <= inside_c;
            p1_a_reg      <= 23'(seq_chh_reg) + 23'(seq_ih_reg[POS_W-1:0]);
            p1_m_reg      <= 29'(seq_t_reg) * 29'(hc_reg);
            p1_iw_reg     <= seq_iw_reg[POS_W-1:0];
            p1_orow_reg   <= seq_orow_reg;
            p1_ocol_reg   <= seq_ocol_reg;
            p1_i_reg      <= seq_i_reg;
            p1_j_reg      <= seq_j_reg;
            p1_last_reg   <= seq_last;
        end
    end

    // stage 2: row times width, add output row
    logic             p2_inside_reg, p2_last_reg;
    logic [SRC_W-1:0] p2_s_reg;
    logic [29:0]      p2_n_reg;
    logic [POS_W-1:0] p2_iw_reg, p2_ocol_reg;
    logic [TAP_W-1:0] p2_i_reg, p2_j_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p2_valid_reg <= 1'b0;
        end else if (rdy2) begin
            p2_valid_reg <= p1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy2) begin
            p2_inside_reg <= p1_inside_reg;
            p2_s_reg      <= SRC_W'(p1_a_reg) * SRC_W'(w_eff);
            p2_n_reg      <= 30'(p1_m_reg) + 30'(p1_orow_reg);
            p2_iw_reg     <= p1_iw_reg;
            p2_ocol_reg   <= p1_ocol_reg;
            p2_i_reg      <= p1_i_reg;
            p2_j_reg      <= p1_j_reg;
            p2_last_reg   <= p1_last_reg;
        end
    end

    // stage 3: source offset, dest times grid width
    logic             p3_pad_reg, p3_last_reg;
    logic [SRC_W-1:0] p3_src_reg;
    logic [DST_W-1:0] p3_d_reg;
    logic [POS_W-1:0] p3_ocol_reg;
    logic [TAP_W-1:0] p3_i_reg, p3_j_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p3_valid_reg <= 1'b0;
        end else if (rdy3) begin
            p3_valid_reg <= p2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy3) begin
            p3_pad_reg  <= !p2_inside_reg;
            p3_src_reg  <= p2_inside_reg ? p2_s_reg + SRC_W'(p2_iw_reg) : '0;
            p3_d_reg    <= DST_W'(p2_n_reg) * DST_W'(wc_reg);
            p3_ocol_reg <= p2_ocol_reg;
            p3_i_reg    <= p2_i_reg;
            p3_j_reg    <= p2_j_reg;
            p3_last_reg <= p2_last_reg;
        end
    end

    // output register
    logic             out_pad_reg, out_last_reg;
    logic [SRC_W-1:0] out_src_reg;
    logic [DST_W-1:0] out_dst_reg;
    logic [TAP_W-1:0] out_i_reg, out_j_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (rdy4) begin
            out_valid_reg <= p3_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy4) begin
            out_pad_reg  <= p3_pad_reg;
            out_src_reg  <= p3_src_reg;
            out_dst_reg  <= p3_d_reg + DST_W'(p3_ocol_reg);
            out_i_reg    <= p3_i_reg;
            out_j_reg    <= p3_j_reg;
            out_last_reg <= p3_last_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_j_reg, out_i_reg, out_dst_reg, out_src_reg};
    assign m_tuser  = out_pad_reg;
    assign m_tlast  = out_last_reg;

    `IAG_ASSERT_NEXT(a_cfg_restarts_grid, cfg_valid && cfg_ready, grid_state_reg == G_LOAD, "config write did not restart grid sizing")
    `IAG_ASSERT_NEXT(a_window_starts_at_tap0, s_tvalid && s_tready, seq_valid_reg && seq_i_reg == '0 && seq_j_reg == '0, "accepted window does not start at first tap")
    `IAG_ASSERT_NEXT(a_last_tap_marked, seq_adv && seq_last, p1_valid_reg && p1_last_reg, "final tap lost its last mark")
    `IAG_ASSERT_NOW(a_pad_has_zero_src, m_tvalid && m_tuser, m_tdata[SRC_W-1:0] == '0, "padding beat carries nonzero source offset")

endmodule
